// ===== hw/rtl/ldr_pkg.sv =====
`timescale 1ns / 1ps

package ldr_pkg;

    localparam int ADC_W      = 12;
    localparam int ANGLE_W    = 18;
    localparam int PULSE_W    = 11;
    localparam int DB_W       = 12;
    localparam int GAIN_W     = 10;
    localparam int STEP_W     = 14;
    localparam int CFG_W      = 18;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_STEP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_STEP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_MIN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_MAX  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_MIN = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_MAX = 3'd7;

    localparam logic [DB_W-1:0]    RST_DEADBAND = 12'd60;
    localparam logic [GAIN_W-1:0]  RST_GAIN     = 10'd6;
    localparam logic [STEP_W-1:0]  RST_MIN_STEP = 14'd150;
    localparam logic [STEP_W-1:0]  RST_MAX_STEP = 14'd1000;
    localparam logic [ANGLE_W-1:0] RST_PAN_MIN  = 18'd10000;
    localparam logic [ANGLE_W-1:0] RST_PAN_MAX  = 18'd170000;
    localparam logic [ANGLE_W-1:0] RST_TILT_MIN = 18'd50000;
    localparam logic [ANGLE_W-1:0] RST_TILT_MAX = 18'd140000;

    localparam logic [ANGLE_W-1:0] RST_PAN_ANGLE  = 18'd90000;
    localparam logic [ANGLE_W-1:0] RST_TILT_ANGLE = 18'd140000;

    // The pulse is 1000 + floor((angle + 90) / 180), capped at 2000, found by a reciprocal multiply.
    localparam logic [PULSE_W-1:0] PULSE_MIN_US   = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US   = 11'd2000;
    localparam logic [ANGLE_W-1:0] PULSE_HALF     = 18'd90;
    localparam logic [ANGLE_W-1:0] PULSE_SAT_MDEG = 18'd179910;
    localparam int                 PULSE_RECIP_W  = 19;
    localparam logic [PULSE_RECIP_W-1:0] PULSE_RECIP = 19'd372828;
    localparam int                 PULSE_SHIFT    = 26;
    localparam int                 PULSE_Q_W      = 10;
    localparam int                 PULSE_PROD_W   = ANGLE_W + PULSE_RECIP_W;

    typedef struct packed {
        logic [ADC_W-1:0] top_left;
        logic [ADC_W-1:0] top_right;
        logic [ADC_W-1:0] bottom_left;
        logic [ADC_W-1:0] bottom_right;
    } in_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pan_angle_mdeg;
        logic [ANGLE_W-1:0] tilt_angle_mdeg;
        logic [PULSE_W-1:0] pan_pulse_us;
        logic [PULSE_W-1:0] tilt_pulse_us;
        logic               pan_moved;
        logic               tilt_moved;
    } out_word_t;

    typedef struct packed {
        logic [DB_W-1:0]    deadband_counts;
        logic [GAIN_W-1:0]  gain_mdeg_per_count;
        logic [STEP_W-1:0]  min_step_mdeg;
        logic [STEP_W-1:0]  max_step_mdeg;
        logic [ANGLE_W-1:0] pan_min_mdeg;
        logic [ANGLE_W-1:0] pan_max_mdeg;
        logic [ANGLE_W-1:0] tilt_min_mdeg;
        logic [ANGLE_W-1:0] tilt_max_mdeg;
    } cfg_t;

endpackage

// ===== hw/rtl/ldr_front.sv =====
`timescale 1ns / 1ps

module ldr_front #(
    parameter int SAMPLES  = 8,
    parameter int ADC_BITS = 12,
    parameter int SUM_W    = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ldr_pkg::in_word_t  in_data,
    input  logic               q_full,
    output logic               q_push,
    output logic [4*SUM_W-1:0] q_data
);
    import ldr_pkg::*;

    localparam int CNT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MASK_INT = (ADC_BITS >= ADC_W) ? ((1 << ADC_W) - 1) : ((1 << ADC_BITS) - 1);
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'(MASK_INT);

    logic [SUM_W-1:0] sum_reg [4];
    logic [SUM_W-1:0] sum_next [4];
    logic [SUM_W-1:0] total [4];
    logic [ADC_W-1:0] raw [4];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             last;
    logic             accept;

    assign raw[0] = in_data.top_left & ADC_MASK;
    assign raw[1] = in_data.top_right & ADC_MASK;
    assign raw[2] = in_data.bottom_left & ADC_MASK;
    assign raw[3] = in_data.bottom_right & ADC_MASK;

    assign last     = (count_reg == CNT_W'(SAMPLES - 1));
    assign in_stall = last && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && last;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            total[i] = sum_reg[i] + SUM_W'(raw[i]);
            q_data[i*SUM_W +: SUM_W] = total[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < 4; i++)
        begin
            sum_next[i] = sum_reg[i];
        end
        if (accept)
        begin
            if (last)
            begin
                count_next = '0;
                for (int i = 0; i < 4; i++)
                begin
                    sum_next[i] = '0;
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                for (int i = 0; i < 4; i++)
                begin
                    sum_next[i] = total[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/ldr_queue.sv =====
`timescale 1ns / 1ps

module ldr_queue #(
    parameter int W = 60
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/ldr_back.sv =====
`timescale 1ns / 1ps

module ldr_back #(
    parameter int SAMPLES = 8,
    parameter int SUM_W   = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ldr_pkg::cfg_t      cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic [4*SUM_W-1:0] q_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ldr_pkg::out_word_t out_data
);
    import ldr_pkg::*;

    // Exact floor division of a group sum by SAMPLES through a rounded-up reciprocal.
    localparam int     DIV_K     = SUM_W + ((SAMPLES > 1) ? $clog2(SAMPLES) : 0);
    localparam int     DIV_M_W   = DIV_K + 1;
    localparam longint DIV_M_INT = ((longint'(1) << DIV_K) + SAMPLES - 1) / SAMPLES;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_INT);
    localparam int     PROD_W    = SUM_W + DIV_M_W;
    localparam int     RAW_W     = ADC_W + GAIN_W;
    localparam int     MOVE_W    = ANGLE_W + 2;

    function automatic logic [ANGLE_W-1:0] move_axis(
        input logic [ANGLE_W-1:0] angle,
        input logic [STEP_W-1:0]  step,
        input logic               up,
        input logic [ANGLE_W-1:0] lo,
        input logic [ANGLE_W-1:0] hi
    );
        logic signed [MOVE_W-1:0] base;
        logic signed [MOVE_W-1:0] delta;
        logic signed [MOVE_W-1:0] cand;
        logic signed [MOVE_W-1:0] lo_s;
        logic signed [MOVE_W-1:0] hi_s;
        logic [ANGLE_W-1:0]       result;
        base  = $signed({2'b00, angle});
        delta = $signed({{(MOVE_W-STEP_W){1'b0}}, step});
        lo_s  = $signed({2'b00, lo});
        hi_s  = $signed({2'b00, hi});
        cand  = up ? (base + delta) : (base - delta);
        if (cand < lo_s)
        begin
            result = lo;
        end
        else if (cand > hi_s)
        begin
            result = hi;
        end
        else
        begin
            result = cand[ANGLE_W-1:0];
        end
        return result;
    endfunction

    logic advance;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_reg [4];

    logic [ADC_W-1:0]  mean [4];
    logic [ADC_W:0]    pair_top;
    logic [ADC_W:0]    pair_bot;
    logic [ADC_W:0]    pair_left;
    logic [ADC_W:0]    pair_right;
    logic [ADC_W-1:0]  av_top;
    logic [ADC_W-1:0]  av_bot;
    logic [ADC_W-1:0]  av_left;
    logic [ADC_W-1:0]  av_right;
    logic [ADC_W-1:0]  abs_v;
    logic [ADC_W-1:0]  abs_h;

    logic              s2_valid_reg;
    logic [ADC_W-1:0]  s2_abs_v_reg;
    logic [ADC_W-1:0]  s2_abs_h_reg;
    logic              s2_tilt_mv_reg;
    logic              s2_pan_mv_reg;
    logic              s2_tilt_up_reg;
    logic              s2_pan_up_reg;

    logic              s3_valid_reg;
    logic [RAW_W-1:0]  s3_raw_v_reg;
    logic [RAW_W-1:0]  s3_raw_h_reg;
    logic              s3_tilt_mv_reg;
    logic              s3_pan_mv_reg;
    logic              s3_tilt_up_reg;
    logic              s3_pan_up_reg;

    logic [STEP_W-1:0] step_v;
    logic [STEP_W-1:0] step_h;

    logic              s4_valid_reg;
    logic [STEP_W-1:0] s4_step_v_reg;
    logic [STEP_W-1:0] s4_step_h_reg;
    logic              s4_tilt_mv_reg;
    logic              s4_pan_mv_reg;
    logic              s4_tilt_up_reg;
    logic              s4_pan_up_reg;

    logic [ANGLE_W-1:0] pan_angle_reg;
    logic [ANGLE_W-1:0] pan_angle_next;
    logic [ANGLE_W-1:0] tilt_angle_reg;
    logic [ANGLE_W-1:0] tilt_angle_next;

    logic              s5_valid_reg;
    logic              s5_tilt_mv_reg;
    logic              s5_pan_mv_reg;

    logic [ANGLE_W-1:0]      pan_x;
    logic [ANGLE_W-1:0]      tilt_x;

    logic                    s6_valid_reg;
    logic [ANGLE_W-1:0]      s6_pan_angle_reg;
    logic [ANGLE_W-1:0]      s6_tilt_angle_reg;
    logic [PULSE_PROD_W-1:0] s6_pan_prod_reg;
    logic [PULSE_PROD_W-1:0] s6_tilt_prod_reg;
    logic                    s6_pan_sat_reg;
    logic                    s6_tilt_sat_reg;
    logic                    s6_tilt_mv_reg;
    logic                    s6_pan_mv_reg;

    logic                    out_valid_reg;
    out_word_t               out_data_reg;
    out_word_t               out_data_next;

    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_valid;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mean[i] = s1_prod_reg[i][DIV_K +: ADC_W];
        end
        pair_top   = {1'b0, mean[0]} + {1'b0, mean[1]};
        pair_bot   = {1'b0, mean[2]} + {1'b0, mean[3]};
        pair_left  = {1'b0, mean[0]} + {1'b0, mean[2]};
        pair_right = {1'b0, mean[1]} + {1'b0, mean[3]};
        av_top     = pair_top[ADC_W:1];
        av_bot     = pair_bot[ADC_W:1];
        av_left    = pair_left[ADC_W:1];
        av_right   = pair_right[ADC_W:1];
        abs_v      = (av_top >= av_bot) ? (av_top - av_bot) : (av_bot - av_top);
        abs_h      = (av_left >= av_right) ? (av_left - av_right) : (av_right - av_left);
    end

    always_comb
    begin
        if (s3_raw_v_reg < RAW_W'(cfg.min_step_mdeg))
        begin
            step_v = cfg.min_step_mdeg;
        end
        else if (s3_raw_v_reg > RAW_W'(cfg.max_step_mdeg))
        begin
            step_v = cfg.max_step_mdeg;
        end
        else
        begin
            step_v = s3_raw_v_reg[STEP_W-1:0];
        end
        if (s3_raw_h_reg < RAW_W'(cfg.min_step_mdeg))
        begin
            step_h = cfg.min_step_mdeg;
        end
        else if (s3_raw_h_reg > RAW_W'(cfg.max_step_mdeg))
        begin
            step_h = cfg.max_step_mdeg;
        end
        else
        begin
            step_h = s3_raw_h_reg[STEP_W-1:0];
        end
    end

    always_comb
    begin
        tilt_angle_next = tilt_angle_reg;
        pan_angle_next  = pan_angle_reg;
        if (advance && s4_valid_reg && s4_tilt_mv_reg)
        begin
            tilt_angle_next = move_axis(tilt_angle_reg, s4_step_v_reg, s4_tilt_up_reg,
                                        cfg.tilt_min_mdeg, cfg.tilt_max_mdeg);
        end
        if (advance && s4_valid_reg && s4_pan_mv_reg)
        begin
            pan_angle_next = move_axis(pan_angle_reg, s4_step_h_reg, s4_pan_up_reg,
                                       cfg.pan_min_mdeg, cfg.pan_max_mdeg);
        end
    end

    assign pan_x  = pan_angle_reg + PULSE_HALF;
    assign tilt_x = tilt_angle_reg + PULSE_HALF;

    always_comb
    begin
        out_data_next.pan_angle_mdeg  = s6_pan_angle_reg;
        out_data_next.tilt_angle_mdeg = s6_tilt_angle_reg;
        out_data_next.pan_pulse_us    = s6_pan_sat_reg ? PULSE_MAX_US :
            PULSE_MIN_US + PULSE_W'(s6_pan_prod_reg[PULSE_SHIFT +: PULSE_Q_W]);
        out_data_next.tilt_pulse_us   = s6_tilt_sat_reg ? PULSE_MAX_US :
            PULSE_MIN_US + PULSE_W'(s6_tilt_prod_reg[PULSE_SHIFT +: PULSE_Q_W]);
        out_data_next.pan_moved       = s6_pan_mv_reg;
        out_data_next.tilt_moved      = s6_tilt_mv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_prod_reg[i] <= PROD_W'(q_data[i*SUM_W +: SUM_W]) * PROD_W'(DIV_M);
            end

            s2_abs_v_reg   <= abs_v;
            s2_abs_h_reg   <= abs_h;
            s2_tilt_mv_reg <= (abs_v > cfg.deadband_counts);
            s2_pan_mv_reg  <= (abs_h > cfg.deadband_counts);
            s2_tilt_up_reg <= (av_bot > av_top);
            s2_pan_up_reg  <= !(av_left > av_right);

            s3_raw_v_reg   <= RAW_W'(s2_abs_v_reg) * RAW_W'(cfg.gain_mdeg_per_count);
            s3_raw_h_reg   <= RAW_W'(s2_abs_h_reg) * RAW_W'(cfg.gain_mdeg_per_count);
            s3_tilt_mv_reg <= s2_tilt_mv_reg;
            s3_pan_mv_reg  <= s2_pan_mv_reg;
            s3_tilt_up_reg <= s2_tilt_up_reg;
            s3_pan_up_reg  <= s2_pan_up_reg;

            s4_step_v_reg  <= step_v;
            s4_step_h_reg  <= step_h;
            s4_tilt_mv_reg <= s3_tilt_mv_reg;
            s4_pan_mv_reg  <= s3_pan_mv_reg;
            s4_tilt_up_reg <= s3_tilt_up_reg;
            s4_pan_up_reg  <= s3_pan_up_reg;

            s5_tilt_mv_reg <= s4_tilt_mv_reg;
            s5_pan_mv_reg  <= s4_pan_mv_reg;

            s6_pan_angle_reg  <= pan_angle_reg;
            s6_tilt_angle_reg <= tilt_angle_reg;
            s6_pan_prod_reg   <= PULSE_PROD_W'(pan_x) * PULSE_PROD_W'(PULSE_RECIP);
            s6_tilt_prod_reg  <= PULSE_PROD_W'(tilt_x) * PULSE_PROD_W'(PULSE_RECIP);
            s6_pan_sat_reg    <= (pan_angle_reg >= PULSE_SAT_MDEG);
            s6_tilt_sat_reg   <= (tilt_angle_reg >= PULSE_SAT_MDEG);
            s6_tilt_mv_reg    <= s5_tilt_mv_reg;
            s6_pan_mv_reg     <= s5_pan_mv_reg;

            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pan_angle_reg  <= RST_PAN_ANGLE;
            tilt_angle_reg <= RST_TILT_ANGLE;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= q_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                s6_valid_reg  <= s5_valid_reg;
                out_valid_reg <= s6_valid_reg;
            end
            pan_angle_reg  <= pan_angle_next;
            tilt_angle_reg <= tilt_angle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pulse_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.pan_pulse_us >= PULSE_MIN_US)
                       && (out_data_reg.pan_pulse_us <= PULSE_MAX_US)
                       && (out_data_reg.tilt_pulse_us >= PULSE_MIN_US)
                       && (out_data_reg.tilt_pulse_us <= PULSE_MAX_US))
        else $error("servo pulse out of range");

    a_angle_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(pan_angle_reg) || !$stable(tilt_angle_reg))
            |-> $past(advance && s4_valid_reg))
        else $error("angle changed without a step in the update stage");

endmodule

// ===== hw/rtl/ldr_sun_tracker_step_control.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_stall        in_data   (ldr_pkg::in_word_t)
// out       output     out_valid / out_stall      out_data  (ldr_pkg::out_word_t)
// cfg       input      cfg_write                  cfg_addr, cfg_wdata
//
// One sensor word is taken per cycle while in_stall is low; every SAMPLES-th word closes a group
// and yields one result word, which passes through the queue and then the seven-stage step
// pipeline behind it.
// Reset is asynchronous and active low; it restores the register defaults, clears the sums
// and puts the axes at their home angles. No clearing pass is needed.
// A stalled output freezes the step pipeline; the two-entry queue keeps the input side
// running until it fills, and in_stall rises only for a word that closes a group.

module ldr_sun_tracker_step_control #(
    parameter int SAMPLES  = 8,
    parameter int ADC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ldr_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ldr_pkg::out_word_t                out_data,
    input  logic                              cfg_write,
    input  logic [ldr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ldr_pkg::CFG_W-1:0]         cfg_wdata
);
    import ldr_pkg::*;

    localparam int SUM_W = $clog2(SAMPLES * ((1 << ADC_W) - 1) + 1);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [4*SUM_W-1:0] q_wr_data;
    logic [4*SUM_W-1:0] q_rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_addr)
                CFG_DEADBAND: cfg_next.deadband_counts     = cfg_wdata[DB_W-1:0];
                CFG_GAIN:     cfg_next.gain_mdeg_per_count = cfg_wdata[GAIN_W-1:0];
                CFG_MIN_STEP: cfg_next.min_step_mdeg       = cfg_wdata[STEP_W-1:0];
                CFG_MAX_STEP: cfg_next.max_step_mdeg       = cfg_wdata[STEP_W-1:0];
                CFG_PAN_MIN:  cfg_next.pan_min_mdeg        = cfg_wdata[ANGLE_W-1:0];
                CFG_PAN_MAX:  cfg_next.pan_max_mdeg        = cfg_wdata[ANGLE_W-1:0];
                CFG_TILT_MIN: cfg_next.tilt_min_mdeg       = cfg_wdata[ANGLE_W-1:0];
                CFG_TILT_MAX: cfg_next.tilt_max_mdeg       = cfg_wdata[ANGLE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband_counts     <= RST_DEADBAND;
            cfg_reg.gain_mdeg_per_count <= RST_GAIN;
            cfg_reg.min_step_mdeg       <= RST_MIN_STEP;
            cfg_reg.max_step_mdeg       <= RST_MAX_STEP;
            cfg_reg.pan_min_mdeg        <= RST_PAN_MIN;
            cfg_reg.pan_max_mdeg        <= RST_PAN_MAX;
            cfg_reg.tilt_min_mdeg       <= RST_TILT_MIN;
            cfg_reg.tilt_max_mdeg       <= RST_TILT_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ldr_front #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS),
        .SUM_W    (SUM_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    ldr_queue #(
        .W (4 * SUM_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd_data)
    );

    ldr_back #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ldr_pkg::*;

    localparam int SAMPLES      = 8;
    localparam int ADC_MAX      = (1 << ADC_W) - 1;
    localparam int LAT_CYCLES   = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_PHASES     = 7;
    localparam int PHASE_GROUPS = 15;
    localparam int N_DIR        = 17;
    localparam int N_REGS       = 8;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

    typedef struct packed {
        in_word_t              word;
        logic                  wr;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_W-1:0]      val;
        logic                  typed;
        out_word_t             want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_write;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    cfg_t        pcfg;
    int unsigned sums [4];
    int          rounds;
    longint      pan_pos;
    longint      tilt_pos;
    out_word_t   steps_due [$];
    int          groups_closed;
    int          fail_count;
    int          burst_left;
    bit          gaps_on;
    bit          hold_req;
    bit          hold_done;

    logic [CFG_ADDR_W-1:0] reg_order [N_REGS] = '{CFG_DEADBAND, CFG_GAIN, CFG_MIN_STEP,
        CFG_MAX_STEP, CFG_PAN_MIN, CFG_PAN_MAX, CFG_TILT_MIN, CFG_TILT_MAX};
    int unsigned reg_width [N_REGS] = '{12, 10, 14, 14, 18, 18, 18, 18};
    int unsigned reg_high [N_REGS]  = '{4095, 1000, 10000, 10000, 180000, 180000, 180000, 180000};
    int unsigned reg_reset [N_REGS] = '{60, 6, 150, 1000, 10000, 170000, 50000, 140000};

    dir_row_t dir_tab [N_DIR] = '{
        '{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, CFG_DEADBAND, 18'd0, 1'b1,
          '{18'd90000, 18'd140000, 11'd1500, 11'd1778, 1'b0, 1'b0}},
        '{'{12'd4095, 12'd4095, 12'd0, 12'd0}, 1'b0, CFG_DEADBAND, 18'd0, 1'b1,
          '{18'd90000, 18'd139000, 11'd1500, 11'd1772, 1'b0, 1'b1}},
        '{'{12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b0, CFG_DEADBAND, 18'd0, 1'b1,
          '{18'd90000, 18'd140000, 11'd1500, 11'd1778, 1'b0, 1'b1}},
        '{'{12'd4095, 12'd0, 12'd4095, 12'd0}, 1'b0, CFG_DEADBAND, 18'd0, 1'b0, '0},
        '{'{12'd0, 12'd4095, 12'd0, 12'd4095}, 1'b0, CFG_DEADBAND, 18'd0, 1'b0, '0},
        '{'{12'd1060, 12'd1060, 12'd1000, 12'd1000}, 1'b0, CFG_DEADBAND, 18'd0, 1'b0, '0},
        '{'{12'd1061, 12'd1061, 12'd1000, 12'd1000}, 1'b0, CFG_DEADBAND, 18'd0, 1'b0, '0},
        '{'{12'd1001, 12'd1001, 12'd1000, 12'd1000}, 1'b1, CFG_DEADBAND, 18'd0, 1'b0, '0},
        '{'{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1, CFG_GAIN, 18'd0, 1'b0, '0},
        '{'{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1, CFG_MIN_STEP, 18'd10000, 1'b0, '0},
        '{'{12'd2500, 12'd100, 12'd300, 12'd4000}, 1'b1, CFG_MAX_STEP, 18'd16383, 1'b0, '0},
        '{'{12'd1234, 12'd777, 12'd3210, 12'd55}, 1'b1, CFG_GAIN, 18'd1023, 1'b0, '0},
        '{'{12'd4095, 12'd0, 12'd4095, 12'd0}, 1'b1, CFG_PAN_MIN, 18'd262143, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 12'd0, 12'd0}, 1'b1, CFG_TILT_MAX, 18'd0, 1'b0, '0},
        '{'{12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b1, CFG_TILT_MIN, 18'd0, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 12'd0, 12'd0}, 1'b1, CFG_DEADBAND, 18'd4095, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CFG_PAN_MAX, 18'd0, 1'b0, '0}
    };

    ldr_sun_tracker_step_control #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic longint step_len(longint mag);
        longint g;
        g = longint'(pcfg.gain_mdeg_per_count);
        return clamp_to(g * mag, longint'(pcfg.min_step_mdeg), longint'(pcfg.max_step_mdeg));
    endfunction

    function automatic logic [PULSE_W-1:0] servo_pulse(longint mdeg);
        longint us;
        us = 1000 + (mdeg + 90) / 180;
        if (us > 2000)
            us = 2000;
        return PULSE_W'(us);
    endfunction

    function automatic bit track_round(input in_word_t w, output out_word_t r);
        logic [ADC_W-1:0] rd [4];
        longint mean [4];
        longint avt, avd, avl, avr, dv, dh, db;
        bit pmov, tmov;
        rd[0] = w.top_left;
        rd[1] = w.top_right;
        rd[2] = w.bottom_left;
        rd[3] = w.bottom_right;
        r = '0;
        for (int i = 0; i < 4; i++)
            sums[i] += 32'(rd[i]);
        rounds++;
        if (rounds < SAMPLES)
            return 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mean[i] = longint'(sums[i] / SAMPLES);
            sums[i] = 0;
        end
        rounds = 0;
        avt = (mean[0] + mean[1]) / 2;
        avd = (mean[2] + mean[3]) / 2;
        avl = (mean[0] + mean[2]) / 2;
        avr = (mean[1] + mean[3]) / 2;
        dv = (avt > avd) ? avt - avd : avd - avt;
        dh = (avl > avr) ? avl - avr : avr - avl;
        db = longint'(pcfg.deadband_counts);
        tmov = dv > db;
        pmov = dh > db;
        if (tmov)
        begin
            tilt_pos = (avd > avt) ? tilt_pos + step_len(dv) : tilt_pos - step_len(dv);
            tilt_pos = clamp_to(tilt_pos, longint'(pcfg.tilt_min_mdeg),
                                longint'(pcfg.tilt_max_mdeg));
        end
        if (pmov)
        begin
            pan_pos = (avl > avr) ? pan_pos - step_len(dh) : pan_pos + step_len(dh);
            pan_pos = clamp_to(pan_pos, longint'(pcfg.pan_min_mdeg),
                               longint'(pcfg.pan_max_mdeg));
        end
        r.pan_angle_mdeg  = ANGLE_W'(pan_pos);
        r.tilt_angle_mdeg = ANGLE_W'(tilt_pos);
        r.pan_pulse_us    = servo_pulse(pan_pos);
        r.tilt_pulse_us   = servo_pulse(tilt_pos);
        r.pan_moved       = pmov;
        r.tilt_moved      = tmov;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [ADC_W-1:0] jitter(logic [ADC_W-1:0] v);
        int x;
        x = int'(v) + int'($urandom_range(0, 60)) - 30;
        if (x < 0)
            x = 0;
        if (x > ADC_MAX)
            x = ADC_MAX;
        return ADC_W'(x);
    endfunction

    always @(posedge clk)
    begin : tracker_check
        out_word_t due;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_addr)
                    CFG_DEADBAND: pcfg.deadband_counts     = cfg_wdata[DB_W-1:0];
                    CFG_GAIN:     pcfg.gain_mdeg_per_count = cfg_wdata[GAIN_W-1:0];
                    CFG_MIN_STEP: pcfg.min_step_mdeg       = cfg_wdata[STEP_W-1:0];
                    CFG_MAX_STEP: pcfg.max_step_mdeg       = cfg_wdata[STEP_W-1:0];
                    CFG_PAN_MIN:  pcfg.pan_min_mdeg        = cfg_wdata[ANGLE_W-1:0];
                    CFG_PAN_MAX:  pcfg.pan_max_mdeg        = cfg_wdata[ANGLE_W-1:0];
                    CFG_TILT_MIN: pcfg.tilt_min_mdeg       = cfg_wdata[ANGLE_W-1:0];
                    CFG_TILT_MAX: pcfg.tilt_max_mdeg       = cfg_wdata[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (track_round(in_data, due))
                begin
                    if (groups_closed < N_DIR && dir_tab[groups_closed].typed)
                        due = dir_tab[groups_closed].want;
                    steps_due.push_back(due);
                    groups_closed++;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (steps_due.size() == 0)
                begin
                    $error("result word with none expected: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    due = steps_due.pop_front();
                    check_field("pan_angle_mdeg", 32'(due.pan_angle_mdeg),
                                32'(out_data.pan_angle_mdeg));
                    check_field("tilt_angle_mdeg", 32'(due.tilt_angle_mdeg),
                                32'(out_data.tilt_angle_mdeg));
                    check_field("pan_pulse_us", 32'(due.pan_pulse_us),
                                32'(out_data.pan_pulse_us));
                    check_field("tilt_pulse_us", 32'(due.tilt_pulse_us),
                                32'(out_data.tilt_pulse_us));
                    check_field("pan_moved", 32'(due.pan_moved), 32'(out_data.pan_moved));
                    check_field("tilt_moved", 32'(due.tilt_moved), 32'(out_data.tilt_moved));
                end
            end
        end
    end

    initial
    begin : rx_pattern
        rx_mode_e mode;
        int seg_left;
        int hold_n;
        mode = RX_FREE;
        seg_left = 0;
        hold_n = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_n++;
                if (hold_n >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:  out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic offer_word(input in_word_t w);
        int g;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on)
            begin
                g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (steps_due.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_group();
        in_word_t base;
        in_word_t w;
        logic [63:0] rbits;
        int kind;
        int off;
        int b;
        int hi;
        kind = $urandom_range(0, 9);
        rbits = {$urandom, $urandom};
        base = rbits[$bits(in_word_t)-1:0];
        if (kind == 7 || kind == 8)
        begin
            b = $urandom_range(0, 3000);
            off = int'(pcfg.deadband_counts) + int'($urandom_range(0, 4)) - 2;
            if (off < 0)
                off = 0;
            hi = (b + off > ADC_MAX) ? ADC_MAX : b + off;
            if ($urandom_range(0, 1))
                base = {ADC_W'(hi), ADC_W'(hi), ADC_W'(b), ADC_W'(b)};
            else
                base = {ADC_W'(hi), ADC_W'(b), ADC_W'(hi), ADC_W'(b)};
            if ($urandom_range(0, 1))
                base = {base.bottom_right, base.bottom_left, base.top_right, base.top_left};
        end
        else if (kind == 9)
        begin
            base.top_left     = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
            base.top_right    = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
            base.bottom_left  = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
            base.bottom_right = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
        end
        for (int k = 0; k < SAMPLES; k++)
        begin
            w = base;
            if (kind <= 1)
            begin
                rbits = {$urandom, $urandom};
                w = rbits[$bits(in_word_t)-1:0];
            end
            else if (kind <= 6)
            begin
                w.top_left     = jitter(base.top_left);
                w.top_right    = jitter(base.top_right);
                w.bottom_left  = jitter(base.bottom_left);
                w.bottom_right = jitter(base.bottom_right);
            end
            offer_word(w);
        end
    endtask

    initial
    begin : stimulus
        in_word_t w;
        logic [CFG_W-1:0] vals [N_REGS];
        logic [CFG_W-1:0] t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_addr = CFG_DEADBAND;
        cfg_wdata = '0;
        pcfg = '{RST_DEADBAND, RST_GAIN, RST_MIN_STEP, RST_MAX_STEP,
                 RST_PAN_MIN, RST_PAN_MAX, RST_TILT_MIN, RST_TILT_MAX};
        for (int i = 0; i < 4; i++)
            sums[i] = 0;
        rounds = 0;
        pan_pos = longint'(RST_PAN_ANGLE);
        tilt_pos = longint'(RST_TILT_ANGLE);
        groups_closed = 0;
        fail_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        hold_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            if (dir_tab[r].wr)
            begin
                drain_results();
                write_reg(dir_tab[r].addr, dir_tab[r].val);
            end
            for (int k = 0; k < SAMPLES; k++)
            begin
                w = dir_tab[r].word;
                // The last round carries extra low bits that the truncated mean must drop.
                if (k == SAMPLES - 1)
                begin
                    w.top_left     = w.top_left | ADC_W'(7);
                    w.top_right    = w.top_right | ADC_W'(7);
                    w.bottom_left  = w.bottom_left | ADC_W'(7);
                    w.bottom_right = w.bottom_right | ADC_W'(7);
                end
                offer_word(w);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_results();
            for (int a = 0; a < N_REGS; a++)
            begin
                if (ph == 0)
                    vals[a] = CFG_W'(reg_reset[a]);
                else
                begin
                    case ($urandom_range(0, 9))
                        0: vals[a] = '0;
                        1: vals[a] = CFG_W'((1 << reg_width[a]) - 1);
                        2: vals[a] = CFG_W'(reg_reset[a]);
                        3: vals[a] = CFG_W'($urandom);
                        default: vals[a] = (reg_order[a] == CFG_DEADBAND)
                            ? CFG_W'($urandom_range(0, 200))
                            : CFG_W'($urandom_range(0, reg_high[a]));
                    endcase
                end
            end
            if (ph == N_PHASES - 1)
                vals = '{18'd0, 18'd1000, 18'd0, 18'd10000, 18'd0, 18'd180000, 18'd0, 18'd180000};
            for (int a = 4; a < N_REGS; a += 2)
            begin
                if (vals[a] > vals[a + 1] && $urandom_range(0, 3) != 0)
                begin
                    t = vals[a];
                    vals[a] = vals[a + 1];
                    vals[a + 1] = t;
                end
            end
            for (int a = 0; a < N_REGS; a++)
                write_reg(reg_order[a], vals[a]);
            gaps_on = (ph % 3 != 1);
            if (ph == 3)
                hold_req = 1'b1;
            for (int g = 0; g < PHASE_GROUPS; g++)
            begin
                if (ph == 5 && g == PHASE_GROUPS / 2)
                    drain_results();
                send_random_group();
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
